@@ rtl/tksh_pkg.sv @@
// Shared types and constants of the top-k smallest score heap.
package tksh_pkg;

	localparam int CNT_W = 6;
	localparam int IDX_W = 7;

	localparam logic [1:0] FUNC_INSERT = 2'd0;
	localparam logic [1:0] FUNC_CLEAR  = 2'd1;
	localparam logic [1:0] FUNC_READ   = 2'd2;

	typedef struct packed {
		logic signed [31:0] ci;
		logic signed [31:0] cj;
		logic signed [15:0] score;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic [1:0]       func;
		entry_t           ent;
		logic [CNT_W-1:0] slot;
	} item_t;

	typedef struct packed {
		logic             accepted;
		logic             slot_valid;
		entry_t           ent;
		logic [CNT_W-1:0] count;
	} result_t;

endpackage

@@ rtl/tksh_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
module tksh_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ rtl/tksh_ctrl.sv @@
// Heap sequencer: sift up, sift down, clear and slot read over the heap RAM.
module tksh_ctrl #(
	parameter int HEAP_DEPTH = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  tksh_pkg::item_t                item,
	input  logic [tksh_pkg::CNT_W-1:0]     cap,
	input  logic                           out_free,
	output logic                           busy,
	output logic                           done,
	output tksh_pkg::result_t              res
);

	localparam int AW = $clog2(HEAP_DEPTH);

	typedef enum logic [3:0] {
		IDLE, UP_RD, UP_CMP, ROOT_RD, ROOT_CMP, DN_RDL, DN_RDR, DN_CMP, RD_WAIT, FIN
	} state_t;

	state_t                          state_q;
	tksh_pkg::item_t                 item_q;
	logic [tksh_pkg::IDX_W-1:0]      k_q;
	logic [tksh_pkg::CNT_W-1:0]      count_q;
	tksh_pkg::entry_t                left_q;
	logic                            has_r_q;
	logic                            accepted_q;
	logic                            valid_q;
	tksh_pkg::entry_t                rent_q;

	logic                            we, re;
	logic [tksh_pkg::IDX_W-1:0]      widx, ridx;
	tksh_pkg::entry_t                wdata;
	logic [tksh_pkg::ENTRY_W-1:0]    rraw;
	tksh_pkg::entry_t                rd;
	tksh_pkg::entry_t                pick;
	logic [tksh_pkg::IDX_W-1:0]      pick_idx;
	logic [tksh_pkg::IDX_W:0]        lidx, cnt_x;

	tksh_ram #(.WIDTH(tksh_pkg::ENTRY_W), .DEPTH(HEAP_DEPTH)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (AW'(widx)),
		.wdata (wdata),
		.re    (re),
		.raddr (AW'(ridx)),
		.rdata (rraw)
	);

	assign rd    = tksh_pkg::entry_t'(rraw);
	assign lidx  = {k_q, 1'b0};
	assign cnt_x = {{(tksh_pkg::IDX_W + 1 - tksh_pkg::CNT_W){1'b0}}, count_q};

	always_comb begin
		if (has_r_q && (rd.score > left_q.score)) begin
			pick     = rd;
			pick_idx = lidx[tksh_pkg::IDX_W-1:0] + 7'd1;
		end else begin
			pick     = left_q;
			pick_idx = lidx[tksh_pkg::IDX_W-1:0];
		end
	end

	always_comb begin
		we    = 1'b0;
		widx  = k_q;
		wdata = item_q.ent;
		re    = 1'b0;
		ridx  = k_q;
		done  = 1'b0;
		case (state_q)
			IDLE: begin
				// A slot read addresses the RAM in the cycle its transaction is taken.
				if (start && (item.func == tksh_pkg::FUNC_READ)) begin
					re   = 1'b1;
					ridx = {1'b0, item.slot};
				end
			end
			UP_RD: begin
				if (k_q > 7'd1) begin
					re   = 1'b1;
					ridx = k_q >> 1;
				end else begin
					we = 1'b1;
				end
			end
			UP_CMP: begin
				we = 1'b1;
				if (item_q.ent.score > rd.score) begin
					wdata = rd;
				end
			end
			ROOT_RD: begin
				re   = 1'b1;
				ridx = 7'd1;
			end
			DN_RDL: begin
				if (lidx <= cnt_x) begin
					re   = 1'b1;
					ridx = lidx[tksh_pkg::IDX_W-1:0];
				end else begin
					we = 1'b1;
				end
			end
			DN_RDR: begin
				if ((lidx + 8'd1) <= cnt_x) begin
					re   = 1'b1;
					ridx = lidx[tksh_pkg::IDX_W-1:0] + 7'd1;
				end
			end
			DN_CMP: begin
				we = 1'b1;
				if (pick.score > item_q.ent.score) begin
					wdata = pick;
				end
			end
			RD_WAIT: begin
			end
			FIN: begin
				done = out_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= IDLE;
			count_q    <= '0;
			accepted_q <= 1'b0;
			valid_q    <= 1'b0;
			has_r_q    <= 1'b0;
			k_q        <= '0;
		end else begin
			case (state_q)
				IDLE: begin
					if (start) begin
						item_q     <= item;
						accepted_q <= 1'b0;
						valid_q    <= 1'b0;
						rent_q     <= '0;
						case (item.func)
							tksh_pkg::FUNC_INSERT: begin
								if (count_q < cap) begin
									k_q     <= {1'b0, count_q} + 7'd1;
									state_q <= UP_RD;
								end else if (count_q != '0) begin
									state_q <= ROOT_RD;
								end else begin
									state_q <= FIN;
								end
							end
							tksh_pkg::FUNC_CLEAR: begin
								count_q <= '0;
								state_q <= FIN;
							end
							tksh_pkg::FUNC_READ: begin
								if ((item.slot != '0) && (item.slot <= count_q)) begin
									state_q <= RD_WAIT;
								end else begin
									state_q <= FIN;
								end
							end
							default: begin
								state_q <= FIN;
							end
						endcase
					end
				end
				UP_RD: begin
					if (k_q > 7'd1) begin
						state_q <= UP_CMP;
					end else begin
						count_q    <= count_q + 6'd1;
						accepted_q <= 1'b1;
						state_q    <= FIN;
					end
				end
				UP_CMP: begin
					if (item_q.ent.score > rd.score) begin
						k_q     <= k_q >> 1;
						state_q <= UP_RD;
					end else begin
						count_q    <= count_q + 6'd1;
						accepted_q <= 1'b1;
						state_q    <= FIN;
					end
				end
				ROOT_RD: begin
					state_q <= ROOT_CMP;
				end
				ROOT_CMP: begin
					if (item_q.ent.score < rd.score) begin
						k_q     <= 7'd1;
						state_q <= DN_RDL;
					end else begin
						state_q <= FIN;
					end
				end
				DN_RDL: begin
					if (lidx <= cnt_x) begin
						state_q <= DN_RDR;
					end else begin
						accepted_q <= 1'b1;
						state_q    <= FIN;
					end
				end
				DN_RDR: begin
					left_q  <= rd;
					has_r_q <= ((lidx + 8'd1) <= cnt_x);
					state_q <= DN_CMP;
				end
				DN_CMP: begin
					if (pick.score > item_q.ent.score) begin
						k_q     <= pick_idx;
						state_q <= DN_RDL;
					end else begin
						accepted_q <= 1'b1;
						state_q    <= FIN;
					end
				end
				RD_WAIT: begin
					valid_q <= 1'b1;
					rent_q  <= rd;
					state_q <= FIN;
				end
				FIN: begin
					if (out_free) begin
						state_q <= IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

	assign busy           = (state_q != IDLE);
	assign res.accepted   = accepted_q;
	assign res.slot_valid = valid_q;
	assign res.ent        = rent_q;
	assign res.count      = count_q;

endmodule

@@ rtl/top_k_smallest_score_heap_top.sv @@
// Top level of the top-k smallest score heap: configuration, sequencer, result register.
// Clear, no-op and empty-slot reads go straight to the result; a valid read first reads its slot. An
// insert while not full climbs the heap level by level from the new leaf; into a full heap it
// is dropped unless its score is below the root's, else it replaces the root and descends
// level by level to a leaf or until a compare stops it. One transaction is in work at a
// time and a stalled result holds off the next.
// Reset clears the entry count, sequencer and result valid flag, sets capacity to 63.
module top_k_smallest_score_heap_top #(
	parameter int HEAP_DEPTH = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         func,
	input  logic signed [31:0] coord_i,
	input  logic signed [31:0] coord_j,
	input  logic signed [15:0] score,
	input  logic [5:0]         slot,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               accepted,
	output logic [5:0]         entry_count,
	output logic               slot_valid,
	output logic signed [31:0] read_i,
	output logic signed [31:0] read_j,
	output logic signed [15:0] read_score,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [5:0]         cfg_data
);

	// Largest entry count the storage holds, never more than a 6-bit count.
	localparam int MAXCAP_I = (HEAP_DEPTH - 1 > 63) ? 63 : HEAP_DEPTH - 1;
	localparam logic [tksh_pkg::CNT_W-1:0] MAXCAP = tksh_pkg::CNT_W'(MAXCAP_I);

	logic [tksh_pkg::CNT_W-1:0] cap_q;
	logic [tksh_pkg::CNT_W-1:0] eff_cap;
	logic                       busy, done, start, out_free;
	tksh_pkg::item_t            item;
	tksh_pkg::result_t          res;
	tksh_pkg::result_t          out_q;
	logic                       out_valid_q;

	// Config writes are always taken; the user must write them only while the block is idle.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= 6'd63;
		end else if (cfg_valid) begin
			cap_q <= cfg_data;
		end
	end

	assign eff_cap = (cap_q > MAXCAP) ? MAXCAP : cap_q;

	// A new transaction is taken whenever the sequencer is idle, even while the
	// previous result still waits in the output register.
	assign in_stall      = busy;
	assign start         = in_valid && !busy;
	assign item.func     = func;
	assign item.ent.ci   = coord_i;
	assign item.ent.cj   = coord_j;
	assign item.ent.score = score;
	assign item.slot     = slot;

	assign out_free = !out_valid_q || !out_stall;

	tksh_ctrl #(.HEAP_DEPTH(HEAP_DEPTH)) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.item     (item),
		.cap      (eff_cap),
		.out_free (out_free),
		.busy     (busy),
		.done     (done),
		.res      (res)
	);

	// Result register: loaded when the sequencer finishes, held while stalled.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			out_q <= res;
		end
	end

	assign out_valid   = out_valid_q;
	assign accepted    = out_q.accepted;
	assign entry_count = out_q.count;
	assign slot_valid  = out_q.slot_valid;
	assign read_i      = out_q.ent.ci;
	assign read_j      = out_q.ent.cj;
	assign read_score  = out_q.ent.score;

endmodule

@@ rtl/tksh_checker.sv @@
// Port-level checker of the top-k smallest score heap, bound to the top level.
module tksh_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic               accepted,
	input logic [5:0]         entry_count,
	input logic               slot_valid,
	input logic signed [31:0] read_i,
	input logic signed [31:0] read_j,
	input logic signed [15:0] read_score
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(read_score) && $stable(entry_count))
		else $error("stalled result changed");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("transaction taken without the block turning busy");

	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(accepted && slot_valid))
		else $error("insert and read flags both set");

	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !slot_valid |-> read_i == 0 && read_j == 0 && read_score == 0)
		else $error("read data not zero without a valid slot");

	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (slot_valid || accepted) |-> entry_count != 0)
		else $error("valid slot or stored entry with an empty heap");

endmodule

bind top_k_smallest_score_heap_top tksh_checker u_tksh_checker (.*);

@@ tb/top_k_smallest_score_heap_top_test.sv @@
// Self-checking testbench of the top-k smallest score heap with its own heap model.
module top_k_smallest_score_heap_top_test;

	localparam int DEPTH = 64;
	localparam int STALL_LIMIT = 20000;
	// Unused func code; the block treats it as a no-operation.
	localparam logic [1:0] FUNC_NOP = 2'd3;

	typedef struct {
		logic               accepted;
		logic [5:0]         count;
		logic               slot_valid;
		logic signed [31:0] ri;
		logic signed [31:0] rj;
		logic signed [15:0] rs;
	} heap_result_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [1:0]         func;
	logic signed [31:0] coord_i;
	logic signed [31:0] coord_j;
	logic signed [15:0] score;
	logic [5:0]         slot;
	logic               out_valid;
	logic               out_stall;
	logic               accepted;
	logic [5:0]         entry_count;
	logic               slot_valid;
	logic signed [31:0] read_i;
	logic signed [31:0] read_j;
	logic signed [15:0] read_score;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [5:0]         cfg_data;

	// Predictor state: a copy of the heap, its fill count and the capacity register.
	logic signed [31:0] mdl_ci [DEPTH];
	logic signed [31:0] mdl_cj [DEPTH];
	logic signed [15:0] mdl_score [DEPTH];
	int                 mdl_count;
	int                 mdl_capacity;

	heap_result_t pending_results[$];
	int           mismatch_count;
	int           idle_cycles = 0;
	int           send_idle_pct;
	int           recv_stall_pct;
	bit           hold_off;

	top_k_smallest_score_heap_top #(.HEAP_DEPTH(DEPTH)) i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.func(func), .coord_i(coord_i), .coord_j(coord_j), .score(score), .slot(slot),
		.out_valid(out_valid), .out_stall(out_stall),
		.accepted(accepted), .entry_count(entry_count), .slot_valid(slot_valid),
		.read_i(read_i), .read_j(read_j), .read_score(read_score),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Computes the result of one operation and updates the heap copy the same way
	// the block does: sift up while not full, replace-root-and-sift-down once full.
	function automatic heap_result_t predict_heap_op(logic [1:0] f, logic signed [31:0] ci,
			logic signed [31:0] cj, logic signed [15:0] s, logic [5:0] sl);
		heap_result_t r;
		int cap;
		int k;
		int c;
		r = '{default: '0};
		cap = (mdl_capacity > DEPTH - 1) ? DEPTH - 1 : mdl_capacity;
		case (f)
			tksh_pkg::FUNC_INSERT: begin
				if (mdl_count < cap) begin
					k = mdl_count + 1;
					while (k > 1 && s > mdl_score[k >> 1]) begin
						mdl_ci[k] = mdl_ci[k >> 1];
						mdl_cj[k] = mdl_cj[k >> 1];
						mdl_score[k] = mdl_score[k >> 1];
						k = k >> 1;
					end
					mdl_ci[k] = ci;
					mdl_cj[k] = cj;
					mdl_score[k] = s;
					mdl_count++;
					r.accepted = 1'b1;
				end else if (mdl_count > 0 && s < mdl_score[1]) begin
					k = 1;
					while (2 * k <= mdl_count) begin
						c = 2 * k;
						if (c + 1 <= mdl_count && mdl_score[c + 1] > mdl_score[c])
							c++;
						if (mdl_score[c] > s) begin
							mdl_ci[k] = mdl_ci[c];
							mdl_cj[k] = mdl_cj[c];
							mdl_score[k] = mdl_score[c];
							k = c;
						end else begin
							break;
						end
					end
					mdl_ci[k] = ci;
					mdl_cj[k] = cj;
					mdl_score[k] = s;
					r.accepted = 1'b1;
				end
			end
			tksh_pkg::FUNC_CLEAR: begin
				mdl_count = 0;
			end
			tksh_pkg::FUNC_READ: begin
				if (sl >= 1 && sl <= mdl_count) begin
					r.slot_valid = 1'b1;
					r.ri = mdl_ci[sl];
					r.rj = mdl_cj[sl];
					r.rs = mdl_score[sl];
				end
			end
			default: ;
		endcase
		r.count = mdl_count[5:0];
		return r;
	endfunction

	// Offers one transaction, holding it until it is taken; the result is predicted
	// at the accepting edge so that the expectation is queued in transaction order.
	// Valid drops after each transaction, while the block is busy anyway.
	task automatic send_op(logic [1:0] f, logic signed [31:0] ci, logic signed [31:0] cj,
			logic signed [15:0] s, logic [5:0] sl);
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
			@(posedge clk);
		in_valid <= 1'b1;
		func <= f;
		coord_i <= ci;
		coord_j <= cj;
		score <= s;
		slot <= sl;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pending_results.push_back(predict_heap_op(f, ci, cj, s, sl));
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Waits until every expected result has been seen, then idles before anything
	// is reconfigured.
	task automatic drain_results();
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_capacity(logic [5:0] value);
		drain_results();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		mdl_capacity = value;
	endtask

	// Scores mostly come from a narrow band so that ties and root compares are common.
	function automatic logic signed [15:0] pick_score();
		case ($urandom_range(9))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			2, 3: return 16'($urandom);
			default: return $signed(16'($urandom_range(40))) - 16'sd20;
		endcase
	endfunction

	task automatic send_random_ops(int n);
		int r;
		repeat (n) begin
			r = $urandom_range(99);
			if (r < 70)
				send_op(tksh_pkg::FUNC_INSERT, $urandom, $urandom, pick_score(),
					6'($urandom));
			else if (r < 95)
				send_op(tksh_pkg::FUNC_READ, $urandom, $urandom, 16'($urandom),
					6'($urandom));
			else if (r < 98)
				send_op(tksh_pkg::FUNC_CLEAR, $urandom, $urandom, 16'($urandom),
					6'($urandom));
			else
				send_op(FUNC_NOP, $urandom, $urandom, 16'($urandom), 6'($urandom));
		end
	endtask

	// Extremes of every field, each operation, ties, and reads outside the heap.
	task automatic test_directed();
		send_op(tksh_pkg::FUNC_READ, 0, 0, 0, 6'd0);
		send_op(tksh_pkg::FUNC_READ, 0, 0, 0, 6'd1);
		send_op(tksh_pkg::FUNC_INSERT, 32'sh7fffffff, 32'sh80000000, 16'sh7fff, 6'd63);
		send_op(tksh_pkg::FUNC_INSERT, 32'sh80000000, 32'sh7fffffff, 16'sh8000, 6'd0);
		send_op(tksh_pkg::FUNC_INSERT, -1, 0, 16'sd0, 6'd0);
		send_op(tksh_pkg::FUNC_INSERT, 5, 6, 16'sd0, 6'd0);
		send_op(tksh_pkg::FUNC_READ, 0, 0, 0, 6'd1);
		send_op(tksh_pkg::FUNC_READ, 0, 0, 0, 6'd4);
		send_op(tksh_pkg::FUNC_READ, 0, 0, 0, 6'd5);
		send_op(tksh_pkg::FUNC_READ, 0, 0, 0, 6'd63);
		send_op(FUNC_NOP, -1, -1, -1, 6'd63);
		send_op(tksh_pkg::FUNC_CLEAR, -1, -1, -1, 6'd63);
		send_op(tksh_pkg::FUNC_READ, 0, 0, 0, 6'd1);
	endtask

	// Small capacity, where the full-heap replacement path dominates.
	task automatic test_full_heap_replace();
		write_capacity(6'd1);
		send_op(tksh_pkg::FUNC_INSERT, 1, 2, 16'sd10, 6'd0);
		send_op(tksh_pkg::FUNC_INSERT, 3, 4, 16'sd10, 6'd0);
		send_op(tksh_pkg::FUNC_INSERT, 5, 6, 16'sd9, 6'd0);
		send_op(tksh_pkg::FUNC_READ, 0, 0, 0, 6'd1);
		send_random_ops(150);
		write_capacity(6'd7);
		send_op(tksh_pkg::FUNC_CLEAR, 0, 0, 0, 6'd0);
		send_random_ops(200);
	endtask

	// Capacity lowered below the fill count, then zero: the heap stays full.
	task automatic test_capacity_lowered();
		write_capacity(6'd20);
		send_op(tksh_pkg::FUNC_CLEAR, 0, 0, 0, 6'd0);
		repeat (20) send_op(tksh_pkg::FUNC_INSERT, $urandom, $urandom, pick_score(), 6'd0);
		write_capacity(6'd5);
		send_random_ops(100);
		write_capacity(6'd0);
		send_random_ops(60);
		send_op(tksh_pkg::FUNC_CLEAR, 0, 0, 0, 6'd0);
		send_random_ops(30);
	endtask

	// Full capacity of 63 under each idling mix.
	task automatic test_random_idling();
		write_capacity(6'd63);
		send_idle_pct = 0; recv_stall_pct = 0;
		send_random_ops(300);
		send_idle_pct = 85;
		send_random_ops(150);
		send_idle_pct = 0; recv_stall_pct = 85;
		send_random_ops(150);
		send_idle_pct = 7; recv_stall_pct = 7;
		send_random_ops(300);
		send_idle_pct = 0; recv_stall_pct = 0;
	endtask

	// The receiver holds off for a long stretch while items are offered.
	task automatic test_back_pressure();
		hold_off = 1'b1;
		fork
			send_random_ops(40);
			begin
				repeat (400) @(posedge clk);
				hold_off = 1'b0;
			end
		join
	endtask

	// Stall is redrawn every cycle from the current mix, or held during a hold-off.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= hold_off || (recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
		end
	end

	// Compares each accepted result with the oldest expectation.
	always @(posedge clk) begin
		heap_result_t exp_r;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result: count %0d", entry_count);
			end else begin
				exp_r = pending_results.pop_front();
				if (accepted !== exp_r.accepted || entry_count !== exp_r.count ||
						slot_valid !== exp_r.slot_valid || read_i !== exp_r.ri ||
						read_j !== exp_r.rj || read_score !== exp_r.rs) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display({"expected acc %0b cnt %0d vld %0b i %0d j %0d s %0d, ",
							"got acc %0b cnt %0d vld %0b i %0d j %0d s %0d"},
							exp_r.accepted, exp_r.count, exp_r.slot_valid, exp_r.ri, exp_r.rj,
							exp_r.rs, accepted, entry_count, slot_valid, read_i, read_j,
							read_score);
				end
			end
		end
	end

	// Watchdog: ends the run after a long stretch with no transaction on any channel.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		mismatch_count = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_off = 1'b0;
		mdl_count = 0;
		mdl_capacity = 63;
		in_valid = 1'b0;
		func = tksh_pkg::FUNC_INSERT;
		coord_i = '0;
		coord_j = '0;
		score = '0;
		slot = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_full_heap_replace();
		test_capacity_lowered();
		test_random_idling();
		test_back_pressure();

		drain_results();
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
